>>> src/dcbs_pkg.sv
// shared constants, types and helper function of the divided clock bit sequencer
package dcbs_pkg;

  // divider bank and selectors
  localparam int unsigned NUM_DIV = 16;
  localparam int unsigned NUM_SEL = 4;
  localparam int unsigned RES_W   = $clog2(NUM_DIV);
  localparam int unsigned SEL_W   = 5;
  localparam int unsigned IDX_W   = 4;

  // selector codes
  localparam int unsigned SEL_OFF  = 0;
  localparam int unsigned SEL_ON   = 1;
  localparam int unsigned SEL_DIV0 = 2;

  // cv scaling
  localparam int unsigned SIZE_W    = 6;
  localparam int unsigned OFS_W     = 6;
  localparam int unsigned CV_W      = 18;
  localparam int unsigned CV_SCALE  = 40960;
  localparam int unsigned CV_MAX    = 153600;
  localparam int unsigned DVD_W     = 20;
  localparam int unsigned DVD_CNT_W = $clog2(DVD_W + 1);
  localparam int unsigned SIZE_MIN  = 4;
  localparam int unsigned SIZE_MAX  = 32;

  // trigger pulse and reset hold window
  localparam int unsigned PULSE_SAMPLES = 48;
  localparam int unsigned PULSE_W       = $clog2(PULSE_SAMPLES + 1);

  // register port
  localparam int unsigned APB_DW = 32;
  localparam int unsigned ADDR_W = 5;

  // register indexes, byte address is 4 * index
  typedef enum logic [2:0] {
    REG_SELECT_A     = 3'd0,
    REG_SELECT_B     = 3'd1,
    REG_SELECT_C     = 3'd2,
    REG_SELECT_D     = 3'd3,
    REG_INVERT_MASK  = 3'd4,
    REG_GATE_INVERT  = 3'd5,
    REG_SCALE_SIZE   = 3'd6,
    REG_START_OFFSET = 3'd7
  } reg_idx_e;

  // register reset values
  localparam logic [SEL_W-1:0]  RST_SELECT_A   = SEL_W'(2);
  localparam logic [SEL_W-1:0]  RST_SELECT_B   = SEL_W'(3);
  localparam logic [SEL_W-1:0]  RST_SELECT_C   = SEL_W'(5);
  localparam logic [SEL_W-1:0]  RST_SELECT_D   = SEL_W'(9);
  localparam logic [SIZE_W-1:0] RST_SCALE_SIZE = SIZE_W'(16);

  // configuration seen by the datapath
  typedef struct packed {
    logic [NUM_SEL-1:0][SEL_W-1:0] select;
    logic [NUM_SEL-1:0]            invert_mask;
    logic                          gate_invert;
    logic [SIZE_W-1:0]             scale_size;
    logic [OFS_W-1:0]              start_offset;
  } cfg_t;

  // commands from the controller
  typedef struct packed {
    logic rst_load;
    logic advance;
    logic hold_tick;
    logic div_start;
    logic cv_load;
    logic finish;
  } cmd_t;

  // status back to the controller
  typedef struct packed {
    logic load_done;
    logic hold_active;
    logic div_done;
    logic out_free;
  } status_t;

  // one selector pick: off, on or one divider bit
  function automatic logic pick(input logic [SEL_W-1:0] sel,
                                input logic [NUM_DIV-1:0] bits);
    logic [SEL_W-1:0] off;
    logic             r;
    off = sel - SEL_W'(SEL_DIV0);
    r   = 1'b0;
    if (sel == SEL_W'(SEL_ON)) begin
      r = 1'b1;
    end else if (sel >= SEL_W'(SEL_DIV0) && sel < SEL_W'(SEL_DIV0 + NUM_DIV)) begin
      r = bits[off[RES_W-1:0]];
    end
    return r;
  endfunction

endpackage

>>> src/dcbs_in_if.sv
// input channel: one word per audio sample with clock and reset edge flags
interface dcbs_in_if ();
  logic valid;
  logic ready;
  logic clock_rise;
  logic reset_rise;

  modport source (output valid, output clock_rise, output reset_rise, input ready);
  modport sink   (input valid, input clock_rise, input reset_rise, output ready);
endinterface

>>> src/dcbs_out_if.sv
// output channel: one result word per input word
interface dcbs_out_if import dcbs_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [CV_W-1:0]     cv_code;
  logic [IDX_W-1:0]    cv_index;
  logic                trigger_out;
  logic [NUM_SEL-1:0]  select_gates;
  logic [NUM_DIV-1:0]  divider_gates;

  modport source (output valid, output cv_code, output cv_index, output trigger_out,
                  output select_gates, output divider_gates, input ready);
  modport sink   (input valid, input cv_code, input cv_index, input trigger_out,
                  input select_gates, input divider_gates, output ready);
endinterface

>>> src/dcbs_regs.sv
// apb configuration registers of the sequencer
module dcbs_regs import dcbs_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready,
  output cfg_t              cfg_o
);

  cfg_t     cfg_q;
  reg_idx_e idx;
  logic     wr_en;

  assign pready = 1'b1;
  assign idx    = reg_idx_e'(paddr[ADDR_W-1:2]);
  assign wr_en  = psel && penable && pwrite;
  assign cfg_o  = cfg_q;

  // register writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.select[0]    <= RST_SELECT_A;
      cfg_q.select[1]    <= RST_SELECT_B;
      cfg_q.select[2]    <= RST_SELECT_C;
      cfg_q.select[3]    <= RST_SELECT_D;
      cfg_q.invert_mask  <= '0;
      cfg_q.gate_invert  <= 1'b0;
      cfg_q.scale_size   <= RST_SCALE_SIZE;
      cfg_q.start_offset <= '0;
    end else if (wr_en) begin
      unique case (idx)
        REG_SELECT_A:     cfg_q.select[0]    <= pwdata[SEL_W-1:0];
        REG_SELECT_B:     cfg_q.select[1]    <= pwdata[SEL_W-1:0];
        REG_SELECT_C:     cfg_q.select[2]    <= pwdata[SEL_W-1:0];
        REG_SELECT_D:     cfg_q.select[3]    <= pwdata[SEL_W-1:0];
        REG_INVERT_MASK:  cfg_q.invert_mask  <= pwdata[NUM_SEL-1:0];
        REG_GATE_INVERT:  cfg_q.gate_invert  <= pwdata[0];
        REG_SCALE_SIZE:   cfg_q.scale_size   <= pwdata[SIZE_W-1:0];
        REG_START_OFFSET: cfg_q.start_offset <= pwdata[OFS_W-1:0];
        default:          cfg_q.start_offset <= cfg_q.start_offset;
      endcase
    end
  end

  // read mux
  always_comb begin
    unique case (idx)
      REG_SELECT_A:     prdata = APB_DW'(cfg_q.select[0]);
      REG_SELECT_B:     prdata = APB_DW'(cfg_q.select[1]);
      REG_SELECT_C:     prdata = APB_DW'(cfg_q.select[2]);
      REG_SELECT_D:     prdata = APB_DW'(cfg_q.select[3]);
      REG_INVERT_MASK:  prdata = APB_DW'(cfg_q.invert_mask);
      REG_GATE_INVERT:  prdata = APB_DW'(cfg_q.gate_invert);
      REG_SCALE_SIZE:   prdata = APB_DW'(cfg_q.scale_size);
      REG_START_OFFSET: prdata = APB_DW'(cfg_q.start_offset);
      default:          prdata = '0;
    endcase
  end

endmodule

>>> src/dcbs_div.sv
// restoring divider, one quotient bit per cycle
module dcbs_div import dcbs_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [DVD_W-1:0]  dividend_i,
  input  logic [SIZE_W-1:0] divisor_i,
  output logic              done_o,
  output logic [CV_W-1:0]   quotient_o
);

  logic                 busy_q;
  logic                 done_q;
  logic [DVD_CNT_W-1:0] cnt_q;
  logic [DVD_W-1:0]     dq_q;
  logic [SIZE_W-2:0]    rem_q;
  logic [SIZE_W-1:0]    div_q;
  logic [SIZE_W-1:0]    trial;
  logic                 qbit;
  logic [SIZE_W-1:0]    diff;

  // trial subtract of the shifted remainder
  assign trial = {rem_q, dq_q[DVD_W-1]};
  assign qbit  = trial >= div_q;
  assign diff  = trial - div_q;

  assign done_o     = done_q;
  assign quotient_o = dq_q[CV_W-1:0];

  // control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= DVD_CNT_W'(DVD_W);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == DVD_CNT_W'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // dividend shifts out while quotient shifts in
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dq_q  <= dividend_i;
      rem_q <= '0;
      div_q <= divisor_i;
    end else if (busy_q) begin
      dq_q  <= {dq_q[DVD_W-2:0], qbit};
      rem_q <= qbit ? diff[SIZE_W-2:0] : trial[SIZE_W-2:0];
    end
  end

endmodule

>>> src/dcbs_dp.sv
// datapath: divider bank, hold and trigger counters, cv register and result register
module dcbs_dp import dcbs_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  cfg_t                cfg_i,
  input  cmd_t                cmd_i,
  output status_t             status_o,
  input  logic                out_ready_i,
  output logic                out_valid_o,
  output logic [CV_W-1:0]     cv_code_o,
  output logic [IDX_W-1:0]    cv_index_o,
  output logic                trigger_out_o,
  output logic [NUM_SEL-1:0]  select_gates_o,
  output logic [NUM_DIV-1:0]  divider_gates_o
);

  logic [NUM_DIV-1:0][RES_W-1:0] res_q, res_d;
  logic [NUM_DIV-1:0]            bits_q, bits_d;
  logic [OFS_W-1:0]              load_left_q;
  logic [PULSE_W-1:0]            hold_q;
  logic [PULSE_W-1:0]            trig_q;
  logic [CV_W-1:0]               cur_cv_q;
  logic [CV_W-1:0]               last_cv_q;
  logic                          last_valid_q;
  logic                          out_valid_q;

  logic [NUM_SEL-1:0]            picks;
  logic [IDX_W-1:0]              index;
  logic [SIZE_W-1:0]             size_clamped;
  logic [DVD_W-1:0]              dividend;
  logic                          div_done;
  logic [CV_W-1:0]               quotient;
  logic                          changed;
  logic [PULSE_W-1:0]            trig_arm;
  logic                          trig_fire;

  // per divider residue and quotient parity, advanced by one step
  always_comb begin
    for (int k = 0; k < NUM_DIV; k++) begin
      if (res_q[k] == RES_W'(k)) begin
        res_d[k]  = '0;
        bits_d[k] = ~bits_q[k];
      end else begin
        res_d[k]  = res_q[k] + 1'b1;
        bits_d[k] = bits_q[k];
      end
    end
  end

  // selector picks and index
  always_comb begin
    for (int i = 0; i < NUM_SEL; i++) begin
      picks[i] = pick(cfg_i.select[i], bits_q);
    end
  end
  assign index = IDX_W'(picks ^ cfg_i.invert_mask);

  // divisor clamp and scaled index
  always_comb begin
    if (cfg_i.scale_size < SIZE_W'(SIZE_MIN)) begin
      size_clamped = SIZE_W'(SIZE_MIN);
    end else if (cfg_i.scale_size > SIZE_W'(SIZE_MAX)) begin
      size_clamped = SIZE_W'(SIZE_MAX);
    end else begin
      size_clamped = cfg_i.scale_size;
    end
  end
  assign dividend = DVD_W'(index) * DVD_W'(CV_SCALE);

  dcbs_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (dividend),
    .divisor_i  (size_clamped),
    .done_o     (div_done),
    .quotient_o (quotient)
  );

  // trigger arming on a cv change
  assign changed   = !last_valid_q || (cur_cv_q != last_cv_q);
  assign trig_arm  = (changed && trig_q < PULSE_W'(PULSE_SAMPLES)) ?
                     PULSE_W'(PULSE_SAMPLES) : trig_q;
  assign trig_fire = trig_arm != '0;

  // status
  assign status_o.load_done   = load_left_q == '0;
  assign status_o.hold_active = hold_q != '0;
  assign status_o.div_done    = div_done;
  assign status_o.out_free    = !out_valid_q || out_ready_i;

  // sequencer state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_q        <= '0;
      bits_q       <= '0;
      load_left_q  <= '0;
      hold_q       <= '0;
      trig_q       <= '0;
      cur_cv_q     <= '0;
      last_cv_q    <= '0;
      last_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      if (cmd_i.rst_load) begin
        res_q        <= '0;
        bits_q       <= '0;
        load_left_q  <= cfg_i.start_offset;
        hold_q       <= PULSE_W'(PULSE_SAMPLES);
        last_valid_q <= 1'b0;
      end
      if (cmd_i.advance) begin
        res_q  <= res_d;
        bits_q <= bits_d;
        if (load_left_q != '0) begin
          load_left_q <= load_left_q - 1'b1;
        end
      end
      if (cmd_i.hold_tick && hold_q != '0) begin
        hold_q <= hold_q - 1'b1;
      end
      if (cmd_i.cv_load) begin
        cur_cv_q <= quotient;
      end
      if (cmd_i.finish) begin
        trig_q       <= trig_arm - PULSE_W'(trig_fire);
        last_cv_q    <= cur_cv_q;
        last_valid_q <= 1'b1;
        out_valid_q  <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // result word
  always_ff @(posedge clk_i) begin
    if (cmd_i.finish) begin
      cv_code_o       <= cur_cv_q;
      cv_index_o      <= index;
      trigger_out_o   <= trig_fire;
      select_gates_o  <= picks;
      divider_gates_o <= bits_q ^ {NUM_DIV{cfg_i.gate_invert}};
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

>>> src/dcbs_ctrl.sv
// controller: sequences reset load, hold, clock step, division and result write
module dcbs_ctrl import dcbs_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_ready_o,
  input  logic    clock_rise_i,
  input  logic    reset_rise_i,
  input  status_t status_i,
  output cmd_t    cmd_o
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_EVAL,
    ST_DSTART,
    ST_DWAIT,
    ST_FIN
  } state_e;

  state_e state_q;
  logic   clk_flag_q;
  logic   rst_flag_q;
  logic   accept;
  logic   step;

  assign in_ready_o = state_q == ST_IDLE;
  assign accept     = in_valid_i && in_ready_o;
  assign step       = clk_flag_q && !status_i.hold_active;

  // state and latched edge flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      clk_flag_q <= 1'b0;
      rst_flag_q <= 1'b0;
    end else begin
      unique case (state_q)
        ST_IDLE: begin
          if (accept) begin
            clk_flag_q <= clock_rise_i;
            rst_flag_q <= reset_rise_i;
            state_q    <= reset_rise_i ? ST_LOAD : ST_EVAL;
          end
        end
        ST_LOAD: begin
          if (status_i.load_done) begin
            state_q <= ST_EVAL;
          end
        end
        ST_EVAL: begin
          state_q <= (rst_flag_q || step) ? ST_DSTART : ST_FIN;
        end
        ST_DSTART: begin
          state_q <= ST_DWAIT;
        end
        ST_DWAIT: begin
          if (status_i.div_done) begin
            state_q <= ST_FIN;
          end
        end
        ST_FIN: begin
          if (status_i.out_free) begin
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  // commands
  always_comb begin
    cmd_o           = '0;
    cmd_o.rst_load  = accept && reset_rise_i;
    cmd_o.advance   = (state_q == ST_LOAD && !status_i.load_done) ||
                      (state_q == ST_EVAL && step);
    cmd_o.hold_tick = state_q == ST_EVAL;
    cmd_o.div_start = state_q == ST_DSTART;
    cmd_o.cv_load   = state_q == ST_DWAIT && status_i.div_done;
    cmd_o.finish    = state_q == ST_FIN && status_i.out_free;
  end

endmodule

>>> src/divided_clock_bit_sequencer.sv
// top level of the divided clock bit sequencer
//
//  port      dir  flow control        word
//  item_i    in   valid / ready       clock_rise, reset_rise
//  result_o  out  valid / ready       cv_code, cv_index, trigger_out,
//                                     select_gates, divider_gates
//  apb       in   psel / penable      eight registers at byte address 4*i
//
// a result is offered after the controller has passed the eval state and, when the cv
// is recomputed, the divider start and wait states of the bit serial divider; the next
// word is taken only after the result write, so the sequencer never overlaps two words
// a word with reset_rise always recomputes the cv and first loads start_offset steps
// into the divider bank, one step per cycle
// a stalled output keeps its result and holds back only the write of the next one
module divided_clock_bit_sequencer import dcbs_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  dcbs_in_if.sink           item_i,
  dcbs_out_if.source        result_o,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready
);

  cfg_t    cfg;
  cmd_t    cmd;
  status_t status;

  // configuration registers
  dcbs_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // controller
  dcbs_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (item_i.valid),
    .in_ready_o   (item_i.ready),
    .clock_rise_i (item_i.clock_rise),
    .reset_rise_i (item_i.reset_rise),
    .status_i     (status),
    .cmd_o        (cmd)
  );

  // datapath
  dcbs_dp u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_i           (cfg),
    .cmd_i           (cmd),
    .status_o        (status),
    .out_ready_i     (result_o.ready),
    .out_valid_o     (result_o.valid),
    .cv_code_o       (result_o.cv_code),
    .cv_index_o      (result_o.cv_index),
    .trigger_out_o   (result_o.trigger_out),
    .select_gates_o  (result_o.select_gates),
    .divider_gates_o (result_o.divider_gates)
  );

endmodule

>>> src/dcbs_checker.sv
// port level checks of the sequencer and their bind to the top level
module dcbs_checker import dcbs_pkg::*; (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              res_valid,
  input logic              res_ready,
  input logic [CV_W-1:0]   res_cv_code,
  input logic              res_trigger,
  input logic              psel,
  input logic              penable,
  input logic              pwrite,
  input logic [ADDR_W-1:0] paddr,
  input logic [APB_DW-1:0] pwdata,
  input logic [APB_DW-1:0] prdata,
  input logic              pready
);

  localparam logic [ADDR_W-1:0] SIZE_ADDR = ADDR_W'({REG_SCALE_SIZE, 2'b00});

  logic            res_take;
  logic            seen_q;
  logic [CV_W-1:0] last_code_q;

  assign res_take = res_valid && res_ready;

  // previous delivered cv code
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_q      <= 1'b0;
      last_code_q <= '0;
    end else if (res_take) begin
      seen_q      <= 1'b1;
      last_code_q <= res_cv_code;
    end
  end

  // a stalled result stays offered
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid && !res_ready |=> res_valid)
    else $error("result dropped while stalled");

  // cv code stays at or below CV_MAX
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid |-> res_cv_code <= CV_W'(CV_MAX))
    else $error("cv code out of range");

  // a changed cv code comes with a trigger
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_take && seen_q && res_cv_code != last_code_q |-> res_trigger)
    else $error("cv change without trigger");

  // written scale size reads back
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    psel && penable && pwrite && pready && paddr == SIZE_ADDR |=>
      (paddr != SIZE_ADDR || prdata[SIZE_W-1:0] == $past(pwdata[SIZE_W-1:0])))
    else $error("scale size readback mismatch");

endmodule

bind divided_clock_bit_sequencer dcbs_checker u_dcbs_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .res_valid   (result_o.valid),
  .res_ready   (result_o.ready),
  .res_cv_code (result_o.cv_code),
  .res_trigger (result_o.trigger_out),
  .psel        (psel),
  .penable     (penable),
  .pwrite      (pwrite),
  .paddr       (paddr),
  .pwdata      (pwdata),
  .prdata      (prdata),
  .pready      (pready)
);
